// ===== rtl/ddo_pkg.sv =====
// shared types, constants and tables for the differential drive odometry block
package ddo_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS = 128;
    localparam int STEP_W = 7;
    localparam int ADDR_W = 4;

    localparam logic [33:0] CORDIC_GAIN = 34'h0_26DD_3B6A;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] TWO_PI_Q29 = 32'hC90F_DAA2;

    localparam logic [31:0] DIST_RESET = 32'd5262285;
    localparam logic [31:0] TURN_RESET = 32'd1265134;
    localparam logic [31:0] RATE_RESET = 32'd1000000;

    localparam logic [1:0] REG_DIST = 2'd0;
    localparam logic [1:0] REG_TURN = 2'd1;
    localparam logic [1:0] REG_RATE = 2'd2;

    typedef struct packed {
        logic [31:0] dist_per_tick;
        logic [31:0] turn_per_tick_diff;
        logic [31:0] stamp_rate;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_PRIME, OP_DELTA, OP_SAVE_S, OP_HEAD, OP_CINIT, OP_CSTEP,
        OP_CSAVE, OP_ADD_X, OP_ADD_Y, OP_QUAT, OP_VZERO, OP_DSTEP, OP_LIN, OP_SAVE_K,
        OP_ANG, OP_PUBLISH
    } dp_op_t;

    typedef enum logic [2:0] {
        MA_SUM, MA_DIFF, MA_SMAG_LO, MA_SMAG_HI, MA_HMAG_LO, MA_HMAG_HI, MA_STAMP
    } mac_a_t;

    typedef enum logic [2:0] {
        MB_DIST, MB_TURN, MB_COS, MB_SIN, MB_STAMP, MB_TWO_PI, MB_K_LO, MB_K_HI
    } mac_b_t;

    typedef struct packed {
        dp_op_t            op;
        logic [STEP_W-1:0] step;
        logic              half;
        logic              mac_en;
        logic              mac_clear;
        mac_a_t            mac_a;
        mac_b_t            mac_b;
        logic [1:0]        mac_shift;
    } cmd_t;

    typedef struct packed {
        logic primed;
        logic dt_zero;
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_MUL_S, S_MUL_H, S_HEAD, S_CINIT, S_CSTEP, S_CSAVE,
        S_PX0, S_PX1, S_PXADD, S_PY0, S_PY1, S_PYADD, S_HINIT, S_HSTEP, S_QUAT,
        S_VZERO, S_LIN0, S_LIN1, S_LDIV, S_LSAVE, S_K, S_KSAVE, S_A0, S_A1, S_A2,
        S_A3, S_ADIV, S_ASAVE, S_DONE
    } ctrl_state_t;

    function automatic logic [31:0] atan_angle(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h2000_0000;
            5'd1:  r = 32'h12E4_051E;
            5'd2:  r = 32'h09FB_385B;
            5'd3:  r = 32'h0511_11D4;
            5'd4:  r = 32'h028B_0D43;
            5'd5:  r = 32'h0145_D7E1;
            5'd6:  r = 32'h00A2_F61E;
            5'd7:  r = 32'h0051_7C55;
            5'd8:  r = 32'h0028_BE53;
            5'd9:  r = 32'h0014_5F2F;
            5'd10: r = 32'h000A_2F98;
            5'd11: r = 32'h0005_17CC;
            5'd12: r = 32'h0002_8BE6;
            5'd13: r = 32'h0001_45F3;
            5'd14: r = 32'h0000_A2FA;
            5'd15: r = 32'h0000_517D;
            5'd16: r = 32'h0000_28BE;
            5'd17: r = 32'h0000_145F;
            5'd18: r = 32'h0000_0A30;
            5'd19: r = 32'h0000_0518;
            5'd20: r = 32'h0000_028C;
            5'd21: r = 32'h0000_0146;
            5'd22: r = 32'h0000_00A3;
            5'd23: r = 32'h0000_0051;
            5'd24: r = 32'h0000_0029;
            5'd25: r = 32'h0000_0014;
            5'd26: r = 32'h0000_000A;
            5'd27: r = 32'h0000_0005;
            5'd28: r = 32'h0000_0003;
            5'd29: r = 32'h0000_0001;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ddo_cfg.sv =====
// apb register file for the odometry scale factors
module ddo_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output ddo_pkg::cfg_t             cfg
);
    import ddo_pkg::*;

    logic [31:0] dist_reg, dist_next;
    logic [31:0] turn_reg, turn_next;
    logic [31:0] rate_reg, rate_next;
    logic [1:0]  index;
    logic        wr_en;

    assign index = paddr[3:2];
    assign wr_en = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        dist_next = dist_reg;
        turn_next = turn_reg;
        rate_next = rate_reg;
        if (wr_en)
        begin
            case (index)
                REG_DIST: dist_next = pwdata;
                REG_TURN: turn_next = pwdata;
                REG_RATE: rate_next = pwdata;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_DIST: prdata = dist_reg;
            REG_TURN: prdata = turn_reg;
            REG_RATE: prdata = rate_reg;
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= DIST_RESET;
            turn_reg <= TURN_RESET;
            rate_reg <= RATE_RESET;
        end
        else
        begin
            dist_reg <= dist_next;
            turn_reg <= turn_next;
            rate_reg <= rate_next;
        end
    end

    assign cfg.dist_per_tick = dist_reg;
    assign cfg.turn_per_tick_diff = turn_reg;
    assign cfg.stamp_rate = rate_reg;

endmodule

// ===== rtl/ddo_ctrl.sv =====
// sequencer that steps the odometry datapath through one sample
module ddo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ddo_pkg::status_t  status,
    output ddo_pkg::cmd_t     cmd
);
    import ddo_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    logic              publish;

    assign publish = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        m_valid_next = publish ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_START;
            S_START:  state_next = status.primed ? S_MUL_S : S_IDLE;
            S_MUL_S:  state_next = S_MUL_H;
            S_MUL_H:  state_next = S_HEAD;
            S_HEAD:   state_next = S_CINIT;
            S_CINIT:
            begin
                count_next = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = S_CSAVE;
            end
            S_CSAVE:  state_next = S_PX0;
            S_PX0:    state_next = S_PX1;
            S_PX1:    state_next = S_PXADD;
            S_PXADD:  state_next = S_PY0;
            S_PY0:    state_next = S_PY1;
            S_PY1:    state_next = S_PYADD;
            S_PYADD:  state_next = S_HINIT;
            S_HINIT:
            begin
                count_next = '0;
                state_next = S_HSTEP;
            end
            S_HSTEP:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = S_QUAT;
            end
            S_QUAT:   state_next = status.dt_zero ? S_VZERO : S_LIN0;
            S_VZERO:  state_next = S_DONE;
            S_LIN0:   state_next = S_LIN1;
            S_LIN1:
            begin
                count_next = '0;
                state_next = S_LDIV;
            end
            S_LDIV:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_W'(DIV_STEPS - 1)) state_next = S_LSAVE;
            end
            S_LSAVE:  state_next = S_K;
            S_K:      state_next = S_KSAVE;
            S_KSAVE:  state_next = S_A0;
            S_A0:     state_next = S_A1;
            S_A1:     state_next = S_A2;
            S_A2:     state_next = S_A3;
            S_A3:
            begin
                count_next = '0;
                state_next = S_ADIV;
            end
            S_ADIV:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_W'(DIV_STEPS - 1)) state_next = S_ASAVE;
            end
            S_ASAVE:  state_next = S_DONE;
            S_DONE:   if (publish) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op = OP_NONE;
        cmd.step = count_reg;
        cmd.half = 1'b0;
        cmd.mac_en = 1'b0;
        cmd.mac_clear = 1'b0;
        cmd.mac_a = MA_SUM;
        cmd.mac_b = MB_DIST;
        cmd.mac_shift = 2'd0;
        case (state_reg)
            S_IDLE:   if (s_tvalid) cmd.op = OP_LOAD;
            S_START:  cmd.op = status.primed ? OP_DELTA : OP_PRIME;
            S_MUL_S:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_clear = 1'b1;
            end
            S_MUL_H:
            begin
                cmd.op = OP_SAVE_S;
                cmd.mac_en = 1'b1;
                cmd.mac_clear = 1'b1;
                cmd.mac_a = MA_DIFF;
                cmd.mac_b = MB_TURN;
            end
            S_HEAD:   cmd.op = OP_HEAD;
            S_CINIT:  cmd.op = OP_CINIT;
            S_CSTEP:  cmd.op = OP_CSTEP;
            S_CSAVE:  cmd.op = OP_CSAVE;
            S_PX0:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_clear = 1'b1;
                cmd.mac_a = MA_SMAG_LO;
                cmd.mac_b = MB_COS;
            end
            S_PX1:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_a = MA_SMAG_HI;
                cmd.mac_b = MB_COS;
                cmd.mac_shift = 2'd1;
            end
            S_PXADD:  cmd.op = OP_ADD_X;
            S_PY0:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_clear = 1'b1;
                cmd.mac_a = MA_SMAG_LO;
                cmd.mac_b = MB_SIN;
            end
            S_PY1:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_a = MA_SMAG_HI;
                cmd.mac_b = MB_SIN;
                cmd.mac_shift = 2'd1;
            end
            S_PYADD:  cmd.op = OP_ADD_Y;
            S_HINIT:
            begin
                cmd.op = OP_CINIT;
                cmd.half = 1'b1;
            end
            S_HSTEP:  cmd.op = OP_CSTEP;
            S_QUAT:   cmd.op = OP_QUAT;
            S_VZERO:  cmd.op = OP_VZERO;
            S_LIN0:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_clear = 1'b1;
                cmd.mac_a = MA_SMAG_LO;
                cmd.mac_b = MB_STAMP;
            end
            S_LIN1:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_a = MA_SMAG_HI;
                cmd.mac_b = MB_STAMP;
                cmd.mac_shift = 2'd1;
            end
            S_LDIV:   cmd.op = OP_DSTEP;
            S_LSAVE:  cmd.op = OP_LIN;
            S_K:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_clear = 1'b1;
                cmd.mac_a = MA_STAMP;
                cmd.mac_b = MB_TWO_PI;
            end
            S_KSAVE:  cmd.op = OP_SAVE_K;
            S_A0:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_clear = 1'b1;
                cmd.mac_a = MA_HMAG_LO;
                cmd.mac_b = MB_K_LO;
            end
            S_A1:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_a = MA_HMAG_LO;
                cmd.mac_b = MB_K_HI;
                cmd.mac_shift = 2'd1;
            end
            S_A2:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_a = MA_HMAG_HI;
                cmd.mac_b = MB_K_LO;
                cmd.mac_shift = 2'd1;
            end
            S_A3:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_a = MA_HMAG_HI;
                cmd.mac_b = MB_K_HI;
                cmd.mac_shift = 2'd2;
            end
            S_ADIV:   cmd.op = OP_DSTEP;
            S_ASAVE:  cmd.op = OP_ANG;
            S_DONE:   if (publish) cmd.op = OP_PUBLISH;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/ddo_dp.sv =====
// odometry datapath: deltas, shared multiplier, cordic, divider and pose state
module ddo_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ddo_pkg::cmd_t     cmd,
    input  ddo_pkg::cfg_t     cfg,
    input  logic [95:0]       in_data,
    output ddo_pkg::status_t  status,
    output logic [191:0]      out_data,
    output logic              out_zero
);
    import ddo_pkg::*;

    // pose state
    logic        primed_reg, primed_next;
    logic [31:0] prev_left_reg, prev_left_next;
    logic [31:0] prev_right_reg, prev_right_next;
    logic [31:0] prev_time_reg, prev_time_next;
    logic [31:0] acc_x_reg, acc_x_next;
    logic [31:0] acc_y_reg, acc_y_next;
    logic [31:0] heading_reg, heading_next;

    // work registers
    logic [31:0]        in_left_reg, in_left_next;
    logic [31:0]        in_right_reg, in_right_next;
    logic [31:0]        in_time_reg, in_time_next;
    logic               sum_neg_reg, sum_neg_next;
    logic               diff_neg_reg, diff_neg_next;
    logic [32:0]        sum_abs_reg, sum_abs_next;
    logic [32:0]        diff_abs_reg, diff_abs_next;
    logic [31:0]        dt_reg, dt_next;
    logic [63:0]        s_mag_reg, s_mag_next;
    logic [63:0]        h_mag_reg, h_mag_next;
    logic [63:0]        k_reg, k_next;
    logic [127:0]       acc_reg, acc_next;
    logic [31:0]        rem_reg, rem_next;
    logic signed [33:0] cx_reg, cx_next;
    logic signed [33:0] cy_reg, cy_next;
    logic signed [33:0] cz_reg, cz_next;
    logic               flip_reg, flip_next;
    logic signed [33:0] cos_reg, cos_next;
    logic signed [33:0] sin_reg, sin_next;
    logic [31:0]        lin_reg, lin_next;
    logic [31:0]        ang_reg, ang_next;
    logic               zero_reg, zero_next;
    logic [15:0]        quat_z_reg, quat_z_next;
    logic [15:0]        quat_w_reg, quat_w_next;
    logic [191:0]       out_data_reg, out_data_next;
    logic               out_zero_reg, out_zero_next;

    // combinational helpers
    logic [31:0]        dl, dr;
    logic signed [32:0] sum_w, diff_w;
    logic [31:0]        ang_in, ang_q, ang_a;
    logic               flip_w;
    logic signed [33:0] xs, ys, at, cfx, cfy;
    logic [33:0]        cos_abs, sin_abs;
    logic [32:0]        mac_a_val;
    logic [31:0]        mac_b_val;
    logic [64:0]        prod;
    logic [127:0]       prod_sh;
    logic [127:0]       pos_rnd, lin_rnd, ang_rnd;
    logic [31:0]        pos_mag;
    logic [32:0]        div_t, div_sub;
    logic               div_ge;

    function automatic logic [15:0] q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] r;
        logic [15:0]        o;
        t = $signed({v[33], v}) + 35'sd16384;
        r = t[34:15];
        if (r > 20'sd32767)
            o = 16'h7FFF;
        else if (r < -20'sd32768)
            o = 16'h8000;
        else
            o = r[15:0];
        return o;
    endfunction

    function automatic logic [31:0] sat_vel(input logic neg, input logic big,
                                            input logic [31:0] low);
        logic [31:0] limit;
        logic [31:0] m;
        limit = neg ? HALF_TURN : POS_LIMIT;
        m = (big || (low > limit)) ? limit : low;
        return neg ? (32'd0 - m) : m;
    endfunction

    assign dl = in_left_reg - prev_left_reg;
    assign dr = in_right_reg - prev_right_reg;
    assign sum_w = $signed({dl[31], dl}) + $signed({dr[31], dr});
    assign diff_w = $signed({dr[31], dr}) - $signed({dl[31], dl});

    // fold the angle into the right half plane
    assign ang_in = cmd.half ? {1'b0, heading_reg[31:1]} : heading_reg;
    assign ang_q = ang_in + QUARTER_TURN;
    assign flip_w = ang_q[31];
    assign ang_a = flip_w ? (ang_in - HALF_TURN) : ang_in;

    assign xs = cx_reg >>> cmd.step[4:0];
    assign ys = cy_reg >>> cmd.step[4:0];
    assign at = $signed({2'b00, atan_angle(cmd.step[4:0])});
    assign cfx = flip_reg ? -cx_reg : cx_reg;
    assign cfy = flip_reg ? -cy_reg : cy_reg;
    assign cos_abs = cos_reg[33] ? (34'd0 - cos_reg) : cos_reg;
    assign sin_abs = sin_reg[33] ? (34'd0 - sin_reg) : sin_reg;

    // shared multiplier
    always_comb
    begin
        case (cmd.mac_a)
            MA_SUM:     mac_a_val = sum_abs_reg;
            MA_DIFF:    mac_a_val = diff_abs_reg;
            MA_SMAG_LO: mac_a_val = {1'b0, s_mag_reg[31:0]};
            MA_SMAG_HI: mac_a_val = {1'b0, s_mag_reg[63:32]};
            MA_HMAG_LO: mac_a_val = {1'b0, h_mag_reg[31:0]};
            MA_HMAG_HI: mac_a_val = {1'b0, h_mag_reg[63:32]};
            MA_STAMP:   mac_a_val = {1'b0, cfg.stamp_rate};
            default:    mac_a_val = 33'd0;
        endcase
        case (cmd.mac_b)
            MB_DIST:   mac_b_val = cfg.dist_per_tick;
            MB_TURN:   mac_b_val = cfg.turn_per_tick_diff;
            MB_COS:    mac_b_val = cos_abs[31:0];
            MB_SIN:    mac_b_val = sin_abs[31:0];
            MB_STAMP:  mac_b_val = cfg.stamp_rate;
            MB_TWO_PI: mac_b_val = TWO_PI_Q29;
            MB_K_LO:   mac_b_val = k_reg[31:0];
            MB_K_HI:   mac_b_val = k_reg[63:32];
            default:   mac_b_val = 32'd0;
        endcase
    end

    assign prod = {32'd0, mac_a_val} * {33'd0, mac_b_val};

    always_comb
    begin
        case (cmd.mac_shift)
            2'd0:    prod_sh = {63'd0, prod};
            2'd1:    prod_sh = {31'd0, prod, 32'd0};
            default: prod_sh = {prod[63:0], 64'd0};
        endcase
    end

    assign pos_rnd = acc_reg + (128'd1 << 46);
    assign pos_mag = pos_rnd[78:47];
    assign lin_rnd = acc_reg + (128'd1 << 16);
    assign ang_rnd = acc_reg + (128'd1 << 44);

    // restoring divide, one quotient bit a step
    assign div_t = {((cmd.step == '0) ? 32'd0 : rem_reg), acc_reg[127]};
    assign div_sub = div_t - {1'b0, dt_reg};
    assign div_ge = (div_t >= {1'b0, dt_reg});

    always_comb
    begin
        primed_next = primed_reg;
        prev_left_next = prev_left_reg;
        prev_right_next = prev_right_reg;
        prev_time_next = prev_time_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        heading_next = heading_reg;
        in_left_next = in_left_reg;
        in_right_next = in_right_reg;
        in_time_next = in_time_reg;
        sum_neg_next = sum_neg_reg;
        diff_neg_next = diff_neg_reg;
        sum_abs_next = sum_abs_reg;
        diff_abs_next = diff_abs_reg;
        dt_next = dt_reg;
        s_mag_next = s_mag_reg;
        h_mag_next = h_mag_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        flip_next = flip_reg;
        cos_next = cos_reg;
        sin_next = sin_reg;
        lin_next = lin_reg;
        ang_next = ang_reg;
        zero_next = zero_reg;
        quat_z_next = quat_z_reg;
        quat_w_next = quat_w_reg;
        out_data_next = out_data_reg;
        out_zero_next = out_zero_reg;

        if (cmd.mac_en)
            acc_next = (cmd.mac_clear ? 128'd0 : acc_reg) + prod_sh;

        case (cmd.op)
            OP_LOAD:
            begin
                in_left_next = in_data[31:0];
                in_right_next = in_data[63:32];
                in_time_next = in_data[95:64];
            end
            OP_PRIME:
            begin
                primed_next = 1'b1;
                prev_left_next = in_left_reg;
                prev_right_next = in_right_reg;
                prev_time_next = in_time_reg;
            end
            OP_DELTA:
            begin
                sum_neg_next = sum_w[32];
                diff_neg_next = diff_w[32];
                sum_abs_next = sum_w[32] ? (33'd0 - sum_w) : sum_w;
                diff_abs_next = diff_w[32] ? (33'd0 - diff_w) : diff_w;
                dt_next = in_time_reg - prev_time_reg;
                prev_left_next = in_left_reg;
                prev_right_next = in_right_reg;
                prev_time_next = in_time_reg;
            end
            OP_SAVE_S: s_mag_next = acc_reg[63:0];
            OP_HEAD:
            begin
                h_mag_next = acc_reg[63:0];
                heading_next = diff_neg_reg ? (heading_reg - acc_reg[31:0])
                                            : (heading_reg + acc_reg[31:0]);
            end
            OP_CINIT:
            begin
                flip_next = flip_w;
                cx_next = CORDIC_GAIN;
                cy_next = 34'sd0;
                cz_next = $signed({{2{ang_a[31]}}, ang_a});
            end
            OP_CSTEP:
            begin
                if (!cz_reg[33])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + at;
                end
            end
            OP_CSAVE:
            begin
                cos_next = cfx;
                sin_next = cfy;
            end
            OP_ADD_X:
                acc_x_next = acc_x_reg + ((sum_neg_reg != cos_reg[33]) ? (32'd0 - pos_mag)
                                                                         : pos_mag);
            OP_ADD_Y:
                acc_y_next = acc_y_reg + ((sum_neg_reg != sin_reg[33]) ? (32'd0 - pos_mag)
                                                                         : pos_mag);
            OP_QUAT:
            begin
                quat_z_next = q15(cfy);
                quat_w_next = q15(cfx);
            end
            OP_VZERO:
            begin
                lin_next = (s_mag_reg == 64'd0) ? 32'd0
                                                : (sum_neg_reg ? HALF_TURN : POS_LIMIT);
                ang_next = (h_mag_reg == 64'd0) ? 32'd0
                                                : (diff_neg_reg ? HALF_TURN : POS_LIMIT);
                zero_next = 1'b1;
            end
            OP_DSTEP:
            begin
                rem_next = div_ge ? div_sub[31:0] : div_t[31:0];
                acc_next = {acc_reg[126:0], div_ge};
            end
            OP_LIN:
                lin_next = sat_vel(sum_neg_reg, |lin_rnd[127:49], lin_rnd[48:17]);
            OP_SAVE_K: k_next = acc_reg[63:0];
            OP_ANG:
            begin
                ang_next = sat_vel(diff_neg_reg, |ang_rnd[127:77], ang_rnd[76:45]);
                zero_next = 1'b0;
            end
            OP_PUBLISH:
            begin
                out_data_next = {ang_reg, lin_reg, quat_w_reg, quat_z_reg,
                                 heading_reg, acc_y_reg, acc_x_reg};
                out_zero_next = zero_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            prev_left_reg <= 32'd0;
            prev_right_reg <= 32'd0;
            prev_time_reg <= 32'd0;
            acc_x_reg <= 32'd0;
            acc_y_reg <= 32'd0;
            heading_reg <= 32'd0;
        end
        else
        begin
            primed_reg <= primed_next;
            prev_left_reg <= prev_left_next;
            prev_right_reg <= prev_right_next;
            prev_time_reg <= prev_time_next;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            heading_reg <= heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_left_reg <= in_left_next;
        in_right_reg <= in_right_next;
        in_time_reg <= in_time_next;
        sum_neg_reg <= sum_neg_next;
        diff_neg_reg <= diff_neg_next;
        sum_abs_reg <= sum_abs_next;
        diff_abs_reg <= diff_abs_next;
        dt_reg <= dt_next;
        s_mag_reg <= s_mag_next;
        h_mag_reg <= h_mag_next;
        k_reg <= k_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        flip_reg <= flip_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
        lin_reg <= lin_next;
        ang_reg <= ang_next;
        zero_reg <= zero_next;
        quat_z_reg <= quat_z_next;
        quat_w_reg <= quat_w_next;
        out_data_reg <= out_data_next;
        out_zero_reg <= out_zero_next;
    end

    assign status.primed = primed_reg;
    assign status.dt_zero = (dt_reg == 32'd0);
    assign out_data = out_data_reg;
    assign out_zero = out_zero_reg;

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// differential drive wheel odometry top level
//
// s_* carries one sample request: left and right tick counters and a timestamp.
// m_* carries the pose, yaw quaternion and velocities; m_tuser flags a zero
// time interval; each velocity then saturates unless its motion is zero.
// the apb port sets the tick scale factors and the timestamp rate.
// the first sample after reset only primes the stored counts and gives no
// result. each later sample runs two 30-step cordic passes on one shared
// rotator and, unless the time interval is zero, two 128-step restoring
// divisions for the velocities; one sample is worked on at a time.
// a finished result waits in the output register, and the next sample is
// accepted and worked on meanwhile; it stalls only at its own finish if the
// receiver still holds m_tready low.
// reset clears the pose, heading, stored counts and the output valid, and
// loads the default scale factors.
module differential_drive_odometry (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [95:0]                s_tdata,  // left_count, right_count, sample_time
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pos_x, pos_y, heading_angle, quat_z, quat_w, lin_vel, ang_vel
    output logic [191:0]               m_tdata,
    output logic                       m_tuser,  // zero_interval
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ddo_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    ddo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ddo_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (s_tdata),
        .status   (status),
        .out_data (m_tdata),
        .out_zero (m_tuser)
    );

endmodule

// ===== bench/odometry_checker.sv =====
// checker that predicts odometry results from accepted samples and compares them
module odometry_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [95:0]                s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [191:0]               m_tdata,
    input  logic                       m_tuser,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [ddo_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output int                         errors,
    output int                         pending
);
    import ddo_pkg::*;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [15:0] quat_z;
        logic [15:0] quat_w;
        logic [31:0] lin_vel;
        logic [31:0] ang_vel;
        logic        zero_dt;
    } pose_t;

    localparam logic [31:0] ARC_STEP [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    pose_t       pose_queue [$];
    logic [31:0] dist_scale, turn_scale, rate;
    logic        has_prev;
    logic [31:0] last_left, last_right, last_stamp;
    logic [31:0] x_acc, y_acc, head_acc;

    assign pending = pose_queue.size();

    function automatic logic [127:0] round_down(logic [127:0] w, int s);
        return (w + (128'd1 << (s - 1))) >> s;
    endfunction

    function automatic void rotate(input logic [31:0] angle, output longint c,
                                   output longint s);
        logic        flip;
        logic [31:0] a;
        longint      x, y, z, xs, ys;
        flip = ((angle + QUARTER_TURN) & HALF_TURN) != 0;
        a = flip ? angle - HALF_TURN : angle;
        z = longint'(signed'(a));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= longint'(ARC_STEP[i]);
            end
            else
            begin
                x += ys; y -= xs; z += longint'(ARC_STEP[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] travel_step(logic neg, logic [63:0] mag, longint c);
        logic        cneg;
        logic [63:0] cm;
        logic [127:0] r;
        cneg = c < 0;
        cm = cneg ? -c : c;
        r = round_down({64'd0, mag} * {64'd0, cm}, 47);
        return (neg != cneg) ? -r[31:0] : r[31:0];
    endfunction

    function automatic logic [31:0] rate_of(logic neg, logic [63:0] mag, logic [63:0] mult,
                                            logic [31:0] dt, int s);
        logic [127:0] r;
        logic [31:0]  limit, m;
        limit = neg ? HALF_TURN : POS_LIMIT;
        r = round_down(({64'd0, mag} * {64'd0, mult}) / {96'd0, dt}, s);
        m = (r[127:32] != 0 || r[31:0] > limit) ? limit : r[31:0];
        return neg ? -m : m;
    endfunction

    function automatic logic [15:0] to_q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic longint wrap_delta(logic [31:0] now, logic [31:0] prior);
        logic [31:0] d;
        d = now - prior;
        return longint'(signed'(d));
    endfunction

    task automatic advance_pose(input logic [95:0] sample);
        logic [31:0] left, right, stamp, dh, dt;
        longint      dl, dr, sum, diff, c, s, hc, hs;
        logic        sneg, dneg;
        logic [63:0] s_mag, h_mag;
        pose_t       p;
        left = sample[31:0];
        right = sample[63:32];
        stamp = sample[95:64];
        if (!has_prev)
        begin
            has_prev = 1'b1;
            last_left = left; last_right = right; last_stamp = stamp;
            return;
        end
        dl = wrap_delta(left, last_left);
        dr = wrap_delta(right, last_right);
        sum = dl + dr;
        diff = dr - dl;
        sneg = sum < 0;
        dneg = diff < 0;
        s_mag = 64'(sneg ? -sum : sum) * 64'(dist_scale);
        h_mag = 64'(dneg ? -diff : diff) * 64'(turn_scale);
        dh = h_mag[31:0];
        head_acc += dneg ? -dh : dh;
        rotate(head_acc, c, s);
        x_acc += travel_step(sneg, s_mag, c);
        y_acc += travel_step(sneg, s_mag, s);
        rotate(head_acc >> 1, hc, hs);
        dt = stamp - last_stamp;
        if (dt == 0)
        begin
            p.lin_vel = s_mag == 0 ? 32'd0 : (sneg ? HALF_TURN : POS_LIMIT);
            p.ang_vel = h_mag == 0 ? 32'd0 : (dneg ? HALF_TURN : POS_LIMIT);
        end
        else
        begin
            p.lin_vel = rate_of(sneg, s_mag, 64'(rate), dt, 17);
            p.ang_vel = rate_of(dneg, h_mag, 64'(rate) * 64'(TWO_PI_Q29), dt, 45);
        end
        last_left = left; last_right = right; last_stamp = stamp;
        p.pos_x = x_acc;
        p.pos_y = y_acc;
        p.heading = head_acc;
        p.quat_z = to_q15(hs);
        p.quat_w = to_q15(hc);
        p.zero_dt = dt == 0;
        pose_queue.push_back(p);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s mismatch: expected %h, actual %h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_t p;
        if (!rst_n)
        begin
            dist_scale <= DIST_RESET;
            turn_scale <= TURN_RESET;
            rate <= RATE_RESET;
            has_prev = 1'b0;
            last_left = '0; last_right = '0; last_stamp = '0;
            x_acc = '0; y_acc = '0; head_acc = '0;
            pose_queue.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3:2] == REG_DIST) dist_scale <= pwdata;
                else if (paddr[3:2] == REG_TURN) turn_scale <= pwdata;
                else if (paddr[3:2] == REG_RATE) rate <= pwdata;
            end
            if (s_tvalid && s_tready)
                advance_pose(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (pose_queue.size() == 0)
                begin
                    errors++;
                    $error("result with no sample waiting");
                end
                else
                begin
                    p = pose_queue.pop_front();
                    check_field("pos_x", p.pos_x, m_tdata[31:0]);
                    check_field("pos_y", p.pos_y, m_tdata[63:32]);
                    check_field("heading_angle", p.heading, m_tdata[95:64]);
                    check_field("quat_z", 32'(p.quat_z), 32'(m_tdata[111:96]));
                    check_field("quat_w", 32'(p.quat_w), 32'(m_tdata[127:112]));
                    check_field("lin_vel", p.lin_vel, m_tdata[159:128]);
                    check_field("ang_vel", p.ang_vel, m_tdata[191:160]);
                    check_field("zero_interval", 32'(p.zero_dt), 32'(m_tuser));
                end
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// testbench top: sample and register stimulus, watchdog and verdict for the odometry block
module tb_top;
    import ddo_pkg::*;

    localparam int SETTLE = 400;
    localparam int QUIET_LIMIT = 5000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [95:0]         s_tdata = '0;   // left_count, right_count, sample_time
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [191:0]        m_tdata;        // pos_x, pos_y, heading_angle, quat_z, quat_w, ...
    logic                m_tuser;        // zero_interval
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  errors, pending;
    int                  quiet = 0;
    logic                steady = 1'b0;
    logic [31:0]         left = '0, right = '0, stamp = '0;

    always #2 clk = ~clk;

    differential_drive_odometry i_dut (.*);

    odometry_checker i_checker (.*);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_sample(logic [31:0] l, logic [31:0] r, logic [31:0] t);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {t, r, l};
        do @(posedge clk); while (!s_tready);
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(index) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic move(logic [31:0] dl, logic [31:0] dr, logic [31:0] dt);
        left += dl;
        right += dr;
        stamp += dt;
        send_sample(left, right, stamp);
    endtask

    task automatic random_samples(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 8)
                move($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                     $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3000));
            else if ($urandom_range(0, 1))
                move($urandom_range(0, 2000) - 1000, $urandom_range(0, 6000),
                     $urandom);
            else
            begin
                left = $urandom;
                right = $urandom;
                stamp = $urandom;
                send_sample(left, right, stamp);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults, directed corners
        send_sample(0, 0, 0);
        send_sample(0, 0, 1000);
        move(100, 100, 1000);
        move(-10, 10, 1000);
        move(0, 0, 0);
        move(5, 5, 0);
        move(-10, -10, 0);
        move(-20, 20, 0);
        move(20, -20, 0);
        send_sample(32'h8000_0080, 32'h7FFF_FF00, 32'h0000_3000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005);
        send_sample(0, 0, 4);
        left = 0; right = 0; stamp = 4;
        move(5, 0, 2);
        move(0, 1500, 10);
        move(0, 3000, 10);
        move(0, 4500, 10);
        move(-3000, 0, 1);
        random_samples(130);
        wait_drained();

        write_reg(REG_DIST, 32'hFFFF_FFFF);
        write_reg(REG_TURN, 32'hFFFF_FFFF);
        write_reg(REG_RATE, 32'hFFFF_FFFF);
        random_samples(150);
        wait_drained();

        write_reg(REG_DIST, 32'h0000_0000);
        write_reg(REG_TURN, 32'h0000_0000);
        write_reg(REG_RATE, 32'h0000_0000);
        random_samples(100);
        wait_drained();

        write_reg(REG_DIST, $urandom);
        write_reg(REG_TURN, $urandom);
        write_reg(REG_RATE, $urandom_range(1, 32'hFFFF_FFFF));
        write_reg(2'd3, $urandom);
        random_samples(150);
        wait_drained();

        steady = 1'b1;
        write_reg(REG_DIST, DIST_RESET);
        write_reg(REG_TURN, TURN_RESET);
        write_reg(REG_RATE, 32'd1);
        random_samples(100);
        steady = 1'b0;
        random_samples(100);

        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
